/* rtl/rep_pkg.sv */
// Shared types and constants for the rotary encoder parameter adjuster.
`default_nettype none

package rep_pkg;

  // Full history patterns that mark one detent, the button history levels and the pin-pair mask.
  localparam logic [7:0] SeqRight  = 8'b11100001;
  localparam logic [7:0] SeqLeft   = 8'b11010010;
  localparam logic [7:0] BtnAllHigh = 8'b11111111;
  localparam logic [7:0] BtnAllLow  = 8'b00000000;
  localparam logic [1:0] PairMask  = 2'b11;

  // Reset values of the configuration registers.
  localparam logic [31:0] StepReset = 32'd1;
  localparam logic [31:0] MinReset  = 32'd0;
  localparam logic [31:0] MaxReset  = 32'd100;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_LEFT  = 2'd2
  } turn_e;

  typedef enum logic [1:0] {
    CFG_STEP = 2'd0,
    CFG_MIN  = 2'd1,
    CFG_MAX  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_LOAD   = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic        pin_a;
    logic        pin_b;
    logic        button_pin;
    logic [31:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] param_out;
    logic [1:0]  turn;
    logic        button_pressed;
  } out_word_t;

  // Status handed from the pin decoder to the parameter unit.
  typedef struct packed {
    turn_e turn;
    logic  pressed;
  } enc_status_t;

endpackage

`default_nettype wire

/* rtl/rotary_encoder_param_adjust.sv */
// Top level: input register, decode and adjust logic, result register.
// An accepted input word passes through the input register and then the result register.
// Throughput: one word per cycle while the result register is not stalled; the state
// update is a combinational path from the input register through the compare and add to the state.
// Reset clears the histories, the button flag and the parameter to zero and
// sets step to 1, min to 0 and max to 100; configuration is taken any cycle.
`default_nettype none

module rotary_encoder_param_adjust import rep_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o
);

  logic [31:0] step_q, min_q, max_q;
  logic        s1_valid_q;
  in_word_t    s1_word_q;
  logic        out_valid_q;
  out_word_t   out_word_q;
  logic        advance;
  enc_status_t status;
  logic [31:0] param_next;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
      min_q  <= MinReset;
      max_q  <= MaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP: step_q <= cfg_data_i;
        CFG_MIN:  min_q  <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // The held word moves on when the result register is free or being drained.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  rep_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .word_i   (s1_word_q),
    .status_o (status)
  );

  rep_param u_param (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .action_i     (s1_word_q.action),
    .load_value_i (s1_word_q.load_value),
    .turn_i       (status.turn),
    .step_i       (step_q),
    .min_i        (min_q),
    .max_i        (max_q),
    .param_o      (param_next)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q.param_out      <= param_next;
      out_word_q.turn           <= status.turn;
      out_word_q.button_pressed <= status.pressed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

/* rtl/rep_decoder.sv */
// Quadrature history, turn detection and button debounce state.
`default_nettype none

module rep_decoder import rep_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire in_word_t    word_i,
  output enc_status_t      status_o
);

  logic [7:0] enc_hist_q, enc_hist_d;
  logic [7:0] btn_hist_q, btn_hist_d;
  logic       pressed_q, pressed_d;
  logic [1:0] pair;

  assign pair = {word_i.pin_b, word_i.pin_a};

  // Next state of both histories and the turn seen this word.
  always_comb begin
    enc_hist_d      = enc_hist_q;
    btn_hist_d      = btn_hist_q;
    pressed_d       = pressed_q;
    status_o.turn   = TURN_NONE;
    if (word_i.action == ACT_SAMPLE) begin
      if (pair != (enc_hist_q[1:0] & PairMask)) begin
        if (enc_hist_q == SeqRight) begin
          status_o.turn = TURN_RIGHT;
        end else if (enc_hist_q == SeqLeft) begin
          status_o.turn = TURN_LEFT;
        end
        enc_hist_d = {enc_hist_q[5:0], pair};
      end
      if (btn_hist_q == BtnAllLow) begin
        pressed_d = 1'b1;
      end else if (btn_hist_q == BtnAllHigh) begin
        pressed_d = 1'b0;
      end
      btn_hist_d = {btn_hist_q[6:0], word_i.button_pin};
    end
    status_o.pressed = pressed_d;
  end

  // State advances only when a word is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_hist_q <= '0;
      btn_hist_q <= '0;
      pressed_q  <= 1'b0;
    end else if (en_i) begin
      enc_hist_q <= enc_hist_d;
      btn_hist_q <= btn_hist_d;
      pressed_q  <= pressed_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/rep_param.sv */
// Held parameter with wrap-around adjust and load.
`default_nettype none

module rep_param import rep_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        action_i,
  input  wire logic [31:0] load_value_i,
  input  wire turn_e       turn_i,
  input  wire logic [31:0] step_i,
  input  wire logic [31:0] min_i,
  input  wire logic [31:0] max_i,
  output logic [31:0]      param_o
);

  logic [31:0] param_q, param_d;

  // Right adds or wraps to min, left subtracts or wraps to max.
  always_comb begin
    param_d = param_q;
    if (action_i == ACT_LOAD) begin
      param_d = load_value_i;
    end else begin
      case (turn_i)
        TURN_RIGHT: param_d = (param_q < max_i) ? param_q + step_i : min_i;
        TURN_LEFT:  param_d = (param_q > min_i) ? param_q - step_i : max_i;
        default:    param_d = param_q;
      endcase
    end
  end

  assign param_o = param_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      param_q <= '0;
    end else if (en_i) begin
      param_q <= param_d;
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench for the rotary encoder parameter adjuster: directed and random pin walks.
module tb;
  import rep_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int LongHold    = 300;
  localparam int PhaseWords  = 190;

  // Tracks the parameter, histories and button flag, and holds expected result words.
  class param_scoreboard;
    logic [31:0] step_size   = StepReset;
    logic [31:0] min_value   = MinReset;
    logic [31:0] max_value   = MaxReset;
    logic [7:0]  enc_hist    = '0;
    logic [7:0]  btn_hist    = '0;
    logic        pressed     = 1'b0;
    logic [31:0] param_value = '0;
    out_word_t   expected_words[$];
    int          errors, checked, rights, lefts, loads;

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_STEP: step_size = val;
        CFG_MIN:  min_value = val;
        CFG_MAX:  max_value = val;
        default: ;
      endcase
    endfunction

    // Work out the result word of one accepted input word.
    function void note_input(in_word_t w);
      turn_e       dir;
      logic [1:0]  pair;
      out_word_t   res;
      dir = TURN_NONE;
      if (w.action == ACT_LOAD) begin
        param_value = w.load_value;
      end else begin
        pair = {w.pin_b, w.pin_a};
        // A detent is decided only when the pin pair moves.
        if (pair != (enc_hist[1:0] & PairMask)) begin
          if (enc_hist == SeqRight) dir = TURN_RIGHT;
          else if (enc_hist == SeqLeft) dir = TURN_LEFT;
          enc_hist = {enc_hist[5:0], pair};
        end
        if (dir == TURN_RIGHT) begin
          param_value = (param_value < max_value) ? param_value + step_size : min_value;
        end else if (dir == TURN_LEFT) begin
          param_value = (param_value > min_value) ? param_value - step_size : max_value;
        end
        // The button flag follows the history before the new sample goes in.
        if (btn_hist == BtnAllLow) pressed = 1'b1;
        else if (btn_hist == BtnAllHigh) pressed = 1'b0;
        btn_hist = {btn_hist[6:0], w.button_pin};
      end
      res.param_out      = param_value;
      res.turn           = dir;
      res.button_pressed = pressed;
      expected_words.push_back(res);
    endfunction

    // Compare one result word with the oldest expected word.
    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: param_out %0h turn %0d pressed %0b",
               got.param_out, got.turn, got.button_pressed);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (want.turn == TURN_RIGHT) rights++;
      if (want.turn == TURN_LEFT) lefts++;
      if (got.param_out !== want.param_out) begin
        $error("param_out: expected %0h, actual %0h", want.param_out, got.param_out);
        errors++;
      end
      if (got.turn !== want.turn) begin
        $error("turn: expected %0d, actual %0d", want.turn, got.turn);
        errors++;
      end
      if (got.button_pressed !== want.button_pressed) begin
        $error("button_pressed: expected %0b, actual %0b",
               want.button_pressed, got.button_pressed);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;

  param_scoreboard sb;
  int idle_pct = 18;
  int stuck_cycles;
  int hold_left;
  bit long_hold_go;
  int words_in;
  int n_settings;
  int walk_idx;
  int walk_step = 1;
  logic btn_level = 1'b0;

  rotary_encoder_param_adjust dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (long_hold_go) begin
      hold_left = LongHold;
      long_hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // Monitor: note accepted input words, check result words, count quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_input(in_word_i);
      words_in++;
      if (in_word_i.action == ACT_LOAD) sb.loads++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  initial begin
    while (stuck_cycles < IdleLimit) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles", IdleLimit);
    $display("simulation failed");
    $finish;
  end

  // Offer one word, with random idle cycles first, and wait until it is taken.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_tick(logic [1:0] pair, logic btn);
    in_word_t w;
    w.action     = ACT_SAMPLE;
    w.pin_b      = pair[1];
    w.pin_a      = pair[0];
    w.button_pin = btn;
    w.load_value = $urandom();
    send_word(w);
  endtask

  task automatic send_load(logic [31:0] val);
    in_word_t w;
    w.action     = ACT_LOAD;
    w.pin_a      = 1'($urandom_range(1));
    w.pin_b      = 1'($urandom_range(1));
    w.button_pin = 1'($urandom_range(1));
    w.load_value = val;
    send_word(w);
  endtask

  // Stop offering and wait until every expected word has come back.
  // The first edge lets the monitor note the word accepted at the last edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Quadrature walk: consecutive indexes give the right-turn pair order.
  function automatic logic [1:0] walk_pair(int idx);
    case (idx)
      0: return 2'd3;
      1: return 2'd2;
      2: return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  // Load values favor the bounds and the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(6))
      0: return '0;
      1: return '1;
      2: return sb.min_value;
      3: return sb.max_value;
      4: return sb.max_value - 1;
      5: return sb.min_value + 1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly clean walks with random direction, plus repeats, jumps, bounces and loads.
  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    logic [1:0] pair;
    r = $urandom_range(99);
    w.action     = ACT_SAMPLE;
    w.load_value = $urandom();
    if ($urandom_range(24) == 0) walk_step = 4 - walk_step;
    if ($urandom_range(15) == 0) btn_level = ~btn_level;
    if (r < 5) begin
      w.action     = ACT_LOAD;
      w.load_value = pick_value();
    end else if (r < 9) begin
      walk_idx = walk_idx;
    end else if (r < 12) begin
      walk_idx = $urandom_range(3);
    end else if (r < 16) begin
      walk_idx = (walk_idx + 4 - walk_step) % 4;
    end else begin
      walk_idx = (walk_idx + walk_step) % 4;
    end
    pair = walk_pair(walk_idx);
    w.pin_b      = pair[1];
    w.pin_a      = pair[0];
    w.button_pin = btn_level ^ ($urandom_range(19) == 0);
    return w;
  endfunction

  // One register setting followed by random words, with a pause in the middle.
  task automatic run_phase(logic [31:0] step, logic [31:0] lo, logic [31:0] hi,
                           bit quiet, bit with_hold);
    write_reg(CFG_STEP, step);
    write_reg(CFG_MIN, lo);
    write_reg(CFG_MAX, hi);
    cfg_we_i <= 1'b0;
    n_settings++;
    idle_pct = quiet ? 0 : 18;
    for (int i = 0; i < PhaseWords; i++) begin
      if (with_hold && i == PhaseWords / 4) long_hold_go = 1'b1;
      if (i == PhaseWords / 2) drain();
      send_word(random_word());
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    n_settings = 1;

    // Start-up: the first tick reports pressed, then a right detent.
    send_tick(2'd3, 1'b0);
    send_tick(2'd2, 1'b0);
    send_tick(2'd0, 1'b0);
    send_tick(2'd1, 1'b0);
    send_tick(2'd3, 1'b0);
    // A second right detent while the button goes high.
    send_tick(2'd2, 1'b1);
    send_tick(2'd0, 1'b1);
    send_tick(2'd1, 1'b1);
    send_tick(2'd3, 1'b1);
    // An unchanged pin pair leaves the history alone.
    send_tick(2'd3, 1'b1);
    // A right detent at the upper bound wraps to the lower bound.
    send_load(32'd100);
    send_tick(2'd2, 1'b1);
    send_tick(2'd0, 1'b1);
    send_tick(2'd1, 1'b1);
    send_tick(2'd3, 1'b1);
    // A left detent at the lower bound wraps to the upper bound.
    send_tick(2'd1, 1'b1);
    send_tick(2'd0, 1'b1);
    send_tick(2'd2, 1'b1);
    send_tick(2'd3, 1'b1);
    // A left detent from all ones, while the button pin goes low.
    send_load('1);
    send_tick(2'd1, 1'b0);
    send_tick(2'd0, 1'b0);
    send_tick(2'd2, 1'b0);
    send_tick(2'd3, 1'b0);
    send_load('0);
    drain();

    // Random phases over several register settings, extremes among them.
    run_phase(32'd3, 32'd0, 32'd20, 1'b0, 1'b0);
    run_phase('1, '1, '0, 1'b0, 1'b0);
    run_phase('0, '0, '1, 1'b0, 1'b1);
    run_phase(32'h8000_0000, 32'd16, 32'hFFFF_FFF0, 1'b1, 1'b0);
    run_phase($urandom(), $urandom(), $urandom(), 1'b0, 1'b0);
    run_phase(StepReset, MinReset, MaxReset, 1'b0, 1'b0);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d result words from %0d input words over %0d register settings.",
             sb.checked, words_in, n_settings);
    $display("Words covered %0d right detents, %0d left detents and %0d loads.",
             sb.rights, sb.lefts, sb.loads);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
